// ----- src/pfc_pkg.sv -----
// shared constants, types and codes of the pulse frame classifier
package pfc_pkg;

	// frame geometry
	localparam int NUM_SAMPLES  = 10;
	localparam int ADC_BITS     = 12;
	localparam int IDX_W        = $clog2(NUM_SAMPLES);
	localparam int SMP_PER_LANE = 2;
	localparam int NUM_LANES    = NUM_SAMPLES / SMP_PER_LANE;

	// field widths
	localparam int CHAN_W  = 16;
	localparam int AMP_W   = 16;
	localparam int WATCH_W = CHAN_W + 1;
	localparam int NUM_WATCH = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = WATCH_W;

	// stream widths
	localparam int IN_BITS  = CHAN_W + AMP_W + NUM_SAMPLES * ADC_BITS;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 2 * IDX_W + 5 * ADC_BITS + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
	localparam int CLS_W    = 2;

	// baseline divide by three through a reciprocal
	localparam int SUM_W     = ADC_BITS + 2;
	localparam int DIV_SHIFT = SUM_W + 2;
	localparam int RECIP     = (2 ** DIV_SHIFT) / 3;
	localparam int PROD_W    = SUM_W + DIV_SHIFT;

	// classification window
	localparam int PED_LIMIT    = 2;
	localparam int PEAK_LO      = 4;
	localparam int PEAK_HI      = 6;
	localparam int TROUGH_LIMIT = 3;

	// register reset values
	localparam logic [AMP_W-1:0]    AMP_THR_RST = AMP_W'(208);
	localparam logic [ADC_BITS-1:0] DELTA_RST   = ADC_BITS'(3);
	localparam logic [WATCH_W-1:0]  WATCH_RST   = '1;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AMP_THR = 3'd0,
		REG_DELTA   = 3'd1,
		REG_WATCH_0 = 3'd2,
		REG_WATCH_1 = 3'd3,
		REG_WATCH_2 = 3'd4,
		REG_WATCH_3 = 3'd5
	} reg_idx_t;

	// frame classes
	typedef enum logic [CLS_W-1:0] {
		CLS_UNWATCHED = 2'd0,
		CLS_LOW       = 2'd1,
		CLS_COSMIC    = 2'd2,
		CLS_SPIKE     = 2'd3
	} cls_t;

	typedef logic [ADC_BITS-1:0] smp_t;
	typedef logic [IDX_W-1:0]    idx_t;

	// peak and trough found over a group of samples
	typedef struct packed {
		smp_t pk_v;
		idx_t pk_i;
		smp_t tr_v;
		idx_t tr_i;
	} lane_res_t;

endpackage

// ----- src/pfc_lane.sv -----
// one lane: peak and trough over its share of the samples
module pfc_lane (
	input  logic [pfc_pkg::SMP_PER_LANE-1:0][pfc_pkg::ADC_BITS-1:0] smp,
	input  logic [pfc_pkg::IDX_W-1:0]                               base_idx,
	output pfc_pkg::lane_res_t                                      res
);
	import pfc_pkg::*;

	// running compare, strict so the first index wins a tie
	always_comb begin
		res.pk_v = smp[0];
		res.tr_v = smp[0];
		res.pk_i = base_idx;
		res.tr_i = base_idx;
		for (int k = 1; k < SMP_PER_LANE; k++) begin
			if (smp[k] > res.pk_v) begin
				res.pk_v = smp[k];
				res.pk_i = base_idx + IDX_W'(k);
			end
			if (smp[k] < res.tr_v) begin
				res.tr_v = smp[k];
				res.tr_i = base_idx + IDX_W'(k);
			end
		end
	end

endmodule

// ----- src/pfc_merge.sv -----
// merging stage: combines the lane results in index order
module pfc_merge (
	input  pfc_pkg::lane_res_t [pfc_pkg::NUM_LANES-1:0] lanes,
	output pfc_pkg::lane_res_t                          merged
);
	import pfc_pkg::*;

	// lower lanes hold lower indexes, so only a strict win replaces
	always_comb begin
		merged = lanes[0];
		for (int l = 1; l < NUM_LANES; l++) begin
			if (lanes[l].pk_v > merged.pk_v) begin
				merged.pk_v = lanes[l].pk_v;
				merged.pk_i = lanes[l].pk_i;
			end
			if (lanes[l].tr_v < merged.tr_v) begin
				merged.tr_v = lanes[l].tr_v;
				merged.tr_i = lanes[l].tr_i;
			end
		end
	end

endmodule

// ----- src/pulse_frame_classifier_top.sv -----
// top level of the pulse frame classifier: config, lanes, merge, output stage
//
// channel  direction  signals                        content
// s_*      in         s_tvalid s_tready s_tdata      one channel frame per beat
// m_*      out        m_tvalid m_tready m_tdata      one classification per beat
//                     m_tuser
// cfg_*    in         cfg_we cfg_index cfg_data      register writes, no wait
//
// two-stage pipeline: lanes, early sums and a first class in stage 1, merge,
// divide and classification in stage 2; one frame per cycle while the output
// is not stalled. each stage holds its beat while the next one is full, a
// stalled output still lets earlier bubbles fill. arst_n clears the valid
// flags and loads the register defaults.
module pulse_frame_classifier_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [pfc_pkg::IN_W-1:0]            s_tdata,  // chan_index, hit_amp, smp_0..smp_9
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [pfc_pkg::OUT_W-1:0]           m_tdata,  // peak_index, trough_index,
	                                                      // peak_value, trough_value,
	                                                      // base_level, early_diff_a,
	                                                      // early_diff_b, peak_in_pedestal
	output logic [pfc_pkg::CLS_W-1:0]           m_tuser,  // frame_class
	input  logic                                cfg_we,
	input  logic [pfc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pfc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import pfc_pkg::*;

	// configuration registers
	logic [AMP_W-1:0]    amp_thr_q;
	logic [ADC_BITS-1:0] delta_q;
	logic [NUM_WATCH-1:0][WATCH_W-1:0] watch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_thr_q <= AMP_THR_RST;
			delta_q   <= DELTA_RST;
			for (int w = 0; w < NUM_WATCH; w++) watch_q[w] <= WATCH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_AMP_THR: amp_thr_q  <= cfg_data[AMP_W-1:0];
				REG_DELTA:   delta_q    <= cfg_data[ADC_BITS-1:0];
				REG_WATCH_0: watch_q[0] <= cfg_data;
				REG_WATCH_1: watch_q[1] <= cfg_data;
				REG_WATCH_2: watch_q[2] <= cfg_data;
				REG_WATCH_3: watch_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// unpack the input beat
	logic [CHAN_W-1:0] chan;
	logic [AMP_W-1:0]  amp;
	logic [NUM_SAMPLES-1:0][ADC_BITS-1:0] smp;

	always_comb begin
		chan = s_tdata[0 +: CHAN_W];
		amp  = s_tdata[CHAN_W +: AMP_W];
		for (int i = 0; i < NUM_SAMPLES; i++)
			smp[i] = s_tdata[CHAN_W + AMP_W + i * ADC_BITS +: ADC_BITS];
	end

	// handshake chain
	logic v_s1, v_s2;
	logic rdy_s1, rdy_s2;
	logic acc_in;

	assign rdy_s2   = !v_s2 || m_tready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign acc_in   = s_tvalid && rdy_s1;

	// lanes
	lane_res_t [NUM_LANES-1:0] lane_res;

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		pfc_lane u_lane (
			.smp      (smp[l * SMP_PER_LANE +: SMP_PER_LANE]),
			.base_idx (IDX_W'(l * SMP_PER_LANE)),
			.res      (lane_res[l])
		);
	end

	// watch list and threshold
	logic watched;
	always_comb begin
		watched = 1'b0;
		for (int w = 0; w < NUM_WATCH; w++)
			if (watch_q[w] == {1'b0, chan}) watched = 1'b1;
	end

	// early differences and baseline sum
	logic [ADC_BITS-1:0] da, db;
	logic [SUM_W-1:0]    sum;
	assign da  = (smp[1] > smp[0]) ? smp[1] - smp[0] : smp[0] - smp[1];
	assign db  = (smp[2] > smp[1]) ? smp[2] - smp[1] : smp[1] - smp[2];
	assign sum = SUM_W'(smp[0]) + SUM_W'(smp[1]) + SUM_W'(smp[2]);

	// stage 1 registers
	lane_res_t [NUM_LANES-1:0] lane_s1;
	logic [SUM_W-1:0]    sum_s1;
	logic [ADC_BITS-1:0] da_s1, db_s1;
	logic                dlt_s1, ana_s1;
	cls_t                cls_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (rdy_s1) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			lane_s1 <= lane_res;
			sum_s1  <= sum;
			da_s1   <= da;
			db_s1   <= db;
			dlt_s1  <= (da < delta_q) || (db < delta_q);
			ana_s1  <= watched && (amp >= amp_thr_q);
			cls_s1  <= !watched ? CLS_UNWATCHED : (amp < amp_thr_q) ? CLS_LOW : CLS_SPIKE;
		end
	end

	// merge the lanes
	lane_res_t merged;
	pfc_merge u_merge (
		.lanes  (lane_s1),
		.merged (merged)
	);

	// divide by three: reciprocal estimate, at most one low, then correct
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  q_est, rem, q;
	assign prod  = PROD_W'(sum_s1) * PROD_W'(RECIP);
	assign q_est = prod[DIV_SHIFT +: SUM_W];
	assign rem   = sum_s1 - SUM_W'(q_est * SUM_W'(3));
	assign q     = (rem >= SUM_W'(3)) ? q_est + SUM_W'(1) : q_est;

	// cosmic window
	logic cosmic;
	assign cosmic = dlt_s1 && (merged.pk_i >= IDX_W'(PEAK_LO)) &&
	                (merged.pk_i <= IDX_W'(PEAK_HI)) && (merged.tr_i < IDX_W'(TROUGH_LIMIT));

	// stage 2 registers
	cls_t                cls_s2;
	lane_res_t           res_s2;
	logic [ADC_BITS-1:0] base_s2, da_s2, db_s2;
	logic                ped_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (rdy_s2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			if (ana_s1) begin
				cls_s2  <= cosmic ? CLS_COSMIC : CLS_SPIKE;
				res_s2  <= merged;
				base_s2 <= q[ADC_BITS-1:0];
				da_s2   <= da_s1;
				db_s2   <= db_s1;
				ped_s2  <= merged.pk_i < IDX_W'(PED_LIMIT);
			end else begin
				cls_s2  <= cls_s1;
				res_s2  <= '0;
				base_s2 <= '0;
				da_s2   <= '0;
				db_s2   <= '0;
				ped_s2  <= 1'b0;
			end
		end
	end

	// pack the output beat
	assign m_tvalid = v_s2;
	assign m_tuser  = cls_s2;
	assign m_tdata  = OUT_W'({ped_s2, db_s2, da_s2, base_s2, res_s2.tr_v, res_s2.pk_v,
	                          res_s2.tr_i, res_s2.pk_i});

	// a frame that is not analyzed carries only its class
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == CLS_UNWATCHED || m_tuser == CLS_LOW) |-> m_tdata == '0)
		else $error("unanalyzed frame with nonzero fields");

	// cosmic class only inside the peak and trough window
	a_cosmic_window: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == CLS_COSMIC |->
		res_s2.pk_i >= IDX_W'(PEAK_LO) && res_s2.pk_i <= IDX_W'(PEAK_HI) &&
		res_s2.tr_i < IDX_W'(TROUGH_LIMIT))
		else $error("cosmic class outside window");

	// merged peak never below merged trough
	a_peak_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> res_s2.pk_v >= res_s2.tr_v)
		else $error("peak below trough");

	// pedestal flag follows the peak index for analyzed frames
	a_pedestal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == CLS_COSMIC || m_tuser == CLS_SPIKE) |->
		ped_s2 == (res_s2.pk_i < IDX_W'(PED_LIMIT)))
		else $error("pedestal flag mismatch");

endmodule
